// File: src/pbrle_pkg.sv
// Shared constants and types for the PackBits run-length decoder.
package pbrle_pkg;

  localparam int unsigned OutCapacity = 49152;
  localparam int unsigned OutPosW     = $clog2(OutCapacity + 1);
  localparam int unsigned SrcW        = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned OffsetW     = 16;

  localparam logic [ByteW-1:0] SkipByte = 8'h80;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_OK      = 2'd1,
    ST_SRC_ERR = 2'd2,
    ST_OUT_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic [ByteW-1:0]   repeat_count;
    logic [OffsetW-1:0] out_offset;
    status_e            status;
    logic               finished;
  } result_t;

endpackage

// File: src/packbits_rle_decoder_top.sv
// Top level of the streaming PackBits (ByteRun1) decoder: decode state and result buffer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | sink      | in_valid_i / in_ready_o   | in_byte_i, first_byte_i
//  out     | source    | out_valid_o / out_ready_i | out_byte_o, repeat_count_o, out_offset_o,
//          |           |                           | status_o, finished_o
//  cfg     | sink      | cfg_we_i (no wait)        | cfg_wdata_i (source_length)
//
// One byte per cycle while in_ready_o is high; a result appears on the outputs the cycle
// after its byte's transaction, or later while an earlier result is still waiting to be taken.
// The decode step is one pass of logic from the state registers into the result register.
// A two-entry result buffer lets input continue while one result is stalled; input stalls
// only when both entries are occupied. Reset clears all decode state and source_length.
module packbits_rle_decoder_top import pbrle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SrcW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic                first_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_byte_o,
  output logic [ByteW-1:0]    repeat_count_o,
  output logic [OffsetW-1:0]  out_offset_o,
  output logic [1:0]          status_o,
  output logic                finished_o
);

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_LITERAL = 2'd2
  } mode_e;

  logic [SrcW-1:0]    src_len_q;
  mode_e              mode_q, mode_d, mode_e_v;
  logic [ByteW-1:0]   lit_q, lit_d, lit_e;
  logic [ByteW-1:0]   pend_q, pend_d, pend_e;
  logic [SrcW-1:0]    spos_q, spos_d, spos_e;
  logic [OutPosW-1:0] opos_q, opos_d, opos_e;
  logic               stop_q, stop_d, stop_e;

  logic               accept, ignore, last;
  logic [SrcW-1:0]    spos_n;
  logic [ByteW:0]     run_len9;
  logic [ByteW-1:0]   run_len, lit_len;
  logic [SrcW:0]      lit_end;
  logic [OutPosW:0]   run_out_end, lit_out_end;
  logic               res_valid;
  result_t            res;
  logic               buf_full;
  result_t            out_data;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = !buf_full;

  always_comb begin
    mode_e_v = mode_q;
    lit_e    = lit_q;
    pend_e   = pend_q;
    spos_e   = spos_q;
    opos_e   = opos_q;
    stop_e   = stop_q;
    if (first_byte_i) begin
      mode_e_v = MODE_CONTROL;
      lit_e    = '0;
      pend_e   = '0;
      spos_e   = '0;
      opos_e   = '0;
      stop_e   = 1'b0;
    end
  end

  assign ignore      = stop_e || (spos_e >= src_len_q);
  assign spos_n      = spos_e + SrcW'(1);
  assign last        = spos_n >= src_len_q;
  assign run_len9    = (ByteW+1)'(257) - {1'b0, in_byte_i};
  assign run_len     = run_len9[ByteW-1:0];
  assign lit_len     = in_byte_i + ByteW'(1);
  assign lit_end     = {1'b0, spos_n} + (SrcW+1)'(lit_len);
  assign run_out_end = {1'b0, opos_e} + (OutPosW+1)'(run_len);
  assign lit_out_end = {1'b0, opos_e} + (OutPosW+1)'(lit_len);

  always_comb begin
    mode_d = mode_e_v;
    lit_d  = lit_e;
    pend_d = pend_e;
    spos_d = spos_e;
    opos_d = opos_e;
    stop_d = stop_e;
    res_valid = 1'b0;
    res.out_byte     = '0;
    res.repeat_count = '0;
    res.out_offset   = OffsetW'(opos_e);
    res.status       = last ? ST_OK : ST_RUNNING;
    res.finished     = last;
    if (!ignore) begin
      spos_d = spos_n;
      case (mode_e_v)
        MODE_RUN: begin
          res_valid        = 1'b1;
          res.out_byte     = in_byte_i;
          res.repeat_count = pend_e;
          opos_d = opos_e + OutPosW'(pend_e);
          mode_d = MODE_CONTROL;
          stop_d = last;
        end
        MODE_LITERAL: begin
          res_valid        = 1'b1;
          res.out_byte     = in_byte_i;
          res.repeat_count = ByteW'(1);
          opos_d = opos_e + OutPosW'(1);
          lit_d  = (lit_e != '0) ? lit_e - ByteW'(1) : '0;
          if (lit_d == '0) begin
            mode_d = MODE_CONTROL;
          end
          stop_d = last;
        end
        default: begin
          if (in_byte_i == SkipByte) begin
            res_valid = last;
            stop_d    = last;
          end else if (in_byte_i[ByteW-1]) begin
            if (last) begin
              res_valid  = 1'b1;
              res.status = ST_SRC_ERR;
              res.finished = 1'b1;
              stop_d     = 1'b1;
            end else if (run_out_end > (OutPosW+1)'(OutCapacity)) begin
              res_valid  = 1'b1;
              res.status = ST_OUT_ERR;
              res.finished = 1'b1;
              stop_d     = 1'b1;
            end else begin
              pend_d = run_len;
              mode_d = MODE_RUN;
            end
          end else begin
            if (lit_end > {1'b0, src_len_q}) begin
              res_valid  = 1'b1;
              res.status = ST_SRC_ERR;
              res.finished = 1'b1;
              stop_d     = 1'b1;
            end else if (lit_out_end > (OutPosW+1)'(OutCapacity)) begin
              res_valid  = 1'b1;
              res.status = ST_OUT_ERR;
              res.finished = 1'b1;
              stop_d     = 1'b1;
            end else begin
              lit_d  = lit_len;
              mode_d = MODE_LITERAL;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q <= '0;
      mode_q    <= MODE_CONTROL;
      lit_q     <= '0;
      pend_q    <= '0;
      spos_q    <= '0;
      opos_q    <= '0;
      stop_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        src_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q <= mode_d;
        lit_q  <= lit_d;
        pend_q <= pend_d;
        spos_q <= spos_d;
        opos_q <= opos_d;
        stop_q <= stop_d;
      end
    end
  end

  pbrle_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data)
  );

  assign out_byte_o     = out_data.out_byte;
  assign repeat_count_o = out_data.repeat_count;
  assign out_offset_o   = out_data.out_offset;
  assign status_o       = out_data.status;
  assign finished_o     = out_data.finished;

  a_running_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_RUNNING) |-> (repeat_count_o != '0 && !finished_o))
    else $error("running result without a write");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stop_q && !first_byte_i) |-> !res_valid)
    else $error("result produced after image end");

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opos_q <= OutPosW'(OutCapacity))
    else $error("output position beyond capacity");

  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_valid && res.finished) |=> stop_q)
    else $error("finished result did not stop decoding");

endmodule

// File: src/pbrle_out_buf.sv
// Result register with a skid stage, so the input side keeps moving while a result waits.
module pbrle_out_buf import pbrle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    take;

  assign take = out_valid_q && ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (take) begin
      out_valid_d = skid_valid_q;
      out_data_d  = skid_data_q;
      skid_valid_d = 1'b0;
    end
    if (push_i) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_data_d  = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule
